/* rtl/core/fvit_pkg.sv */
// Package for the flat vector index: field widths, operation, status and
// register codes, score limits and parameter defaults.
// No dependencies.
package fvit_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int DIM_MAX_DEF    = 64;
    localparam int K_MAX_DEF      = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int OP_W       = 2;
    localparam int KEY_W      = 31;
    localparam int STAT_W     = 2;
    localparam int RANK_W     = 4;
    localparam int RKEY_W     = 32;
    localparam int DIST_W     = 48;
    localparam int RES_FIX_W  = STAT_W + RANK_W + RKEY_W + DIST_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int DIM_W      = 7;
    localparam int TOPK_W     = 5;
    localparam int TERM_W     = 64;
    localparam int SQ_LIM_W   = 24;

    typedef enum logic [OP_W-1:0] {
        OP_CLR = 2'd0,
        OP_ADD = 2'd1,
        OP_QRY = 2'd2,
        OP_RM  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PARM = 2'd1,
        ST_INVALID  = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_METRIC   = 2'd0,
        CFG_DIM      = 2'd1,
        CFG_TOPK     = 2'd2,
        CFG_USE_KEYS = 2'd3
    } t_cfg_idx;

    localparam logic             METRIC_RST = 1'b0;
    localparam logic [DIM_W-1:0] DIM_RST    = 7'd64;
    localparam logic [TOPK_W-1:0] TOPK_RST  = 5'd1;
    localparam logic             USEK_RST   = 1'b0;

    localparam logic signed [DIST_W-1:0] DIST_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [DIST_W-1:0] DIST_LO = 48'sh8000_0000_0000;

endpackage

/* rtl/core/flat_vector_index_topk.sv */
// Flat vector index with exact k-nearest search over a single shared
// multiply-accumulate unit and a sequential insertion list.
// Depends on fvit_pkg.

// Vectors arrive one element per beat on the slave side (tuser is the
// operation) and are taken one per cycle while idle; an element beat that
// is not the last of its vector produces no result. An add commit pads the
// rest of the slot with zeros, then returns one result. A query commit pads
// its buffer with zeros up to DIM_MAX, then walks every stored slot: each
// slot passes through the multiply-accumulate pipe and then insertion
// compares into the ranked list; the query then sends its top_k result
// beats, each set up in S_OUT_KEY and S_OUT_LD and held in S_OUT_WAIT
// until the sink takes it. A remove by key scans the key memory with one
// read and one compare per slot, and every remove that finds its slot
// copies the last slot into it over the vector memory port. Clear answers
// at once. No clearing pass runs after reset. The block accepts nothing
// while an item is in work or its result beat waits to be taken.
module flat_vector_index_topk #(
    parameter int CAPACITY   = fvit_pkg::CAPACITY_DEF,
    parameter int DIM_MAX    = fvit_pkg::DIM_MAX_DEF,
    parameter int K_MAX      = fvit_pkg::K_MAX_DEF,
    parameter int VALUE_BITS = fvit_pkg::VALUE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fvit_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [fvit_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // value, key
    input  logic [((VALUE_BITS+fvit_pkg::KEY_W+7)/8)*8-1:0] i_s_tdata,
    // op
    input  logic [fvit_pkg::OP_W-1:0]              i_s_tuser,
    input  logic                                   i_s_tlast,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // status, rank, result_key, distance, count
    output logic [((fvit_pkg::RES_FIX_W+$clog2(CAPACITY+1)+7)/8)*8-1:0] o_m_tdata,
    output logic                                   o_m_tlast
);
    import fvit_pkg::*;

    localparam int VB      = VALUE_BITS;
    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int E_W     = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int EC_W    = $clog2(DIM_MAX + 1);
    localparam int AW      = $clog2(CAPACITY * DIM_MAX);
    localparam int KW      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int PW      = $clog2(K_MAX + 1);
    localparam int OUT_W   = ((RES_FIX_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_RES      = 10'b00_0000_0010,
        S_PAD_V    = 10'b00_0000_0100,
        S_PAD_Q    = 10'b00_0000_1000,
        S_RUN      = 10'b00_0001_0000,
        S_INS      = 10'b00_0010_0000,
        S_OUT_KEY  = 10'b00_0100_0000,
        S_OUT_LD   = 10'b00_1000_0000,
        S_OUT_WAIT = 10'b01_0000_0000,
        S_RM_RD    = 10'b10_0000_0000
    } t_state;

    // Compare and copy of a remove run in a phase register of their own, apart from the main state.
    typedef enum logic [1:0] {
        RM_NONE = 2'd0,
        RM_CMP  = 2'd1,
        RM_COPY = 2'd2
    } t_rm_phase;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [RANK_W-1:0]        rank;
        logic signed [RKEY_W-1:0] rkey;
        logic signed [DIST_W-1:0] distance;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } t_res;

    function automatic t_res mk_single(input t_status st, input logic [COUNT_W-1:0] cnt);
        t_res r;
        r.status   = st;
        r.rank     = '0;
        r.rkey     = '1;
        r.distance = '0;
        r.count    = cnt;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic logic [AW-1:0] vaddr(input logic [SLOT_W-1:0] slot,
                                            input logic [EC_W-1:0] e);
        return AW'(slot) * AW'(DIM_MAX) + AW'(e);
    endfunction

    // Control and configuration registers.
    t_state               r_state;
    t_rm_phase            r_rm;
    logic                 r_metric;
    logic [DIM_W-1:0]     r_dim;
    logic [TOPK_W-1:0]    r_top_k;
    logic                 r_use_keys;
    logic [COUNT_W-1:0]   r_count;
    logic [EC_W-1:0]      r_ec;
    logic [EC_W-1:0]      r_e;
    logic [E_W-1:0]       r_ed;
    logic                 r_rd_v;
    logic                 r_term_v;
    logic                 r_cp_v;
    logic                 r_m_valid;
    t_res                 r_res;
    logic [SLOT_W-1:0]    r_slot;
    logic [SLOT_W-1:0]    r_scan;
    logic [SLOT_W-1:0]    r_rm_slot;
    logic [KEY_W-1:0]     r_key;
    logic [PW-1:0]        r_p;
    logic [PW-1:0]        r_len;
    logic [PW-1:0]        r_j;
    logic signed [DIST_W-1:0] r_acc;
    logic signed [TERM_W-1:0] r_term;

    // Storage.
    logic signed [VB-1:0]     r_vmem [CAPACITY*DIM_MAX];
    logic [KEY_W-1:0]         r_kmem [CAPACITY];
    logic signed [VB-1:0]     r_qmem [DIM_MAX];
    logic signed [VB-1:0]     r_vd;
    logic signed [VB-1:0]     r_qd;
    logic [KEY_W-1:0]         r_kd;
    logic signed [DIST_W-1:0] r_best_score [K_MAX];
    logic [SLOT_W-1:0]        r_best_slot  [K_MAX];

    // Input beat fields.
    logic                 in_acc;
    t_op                  in_op;
    logic signed [VB-1:0] in_val;
    logic [KEY_W-1:0]     in_key;

    assign o_s_tready = (r_state == S_IDLE) && (r_rm == RM_NONE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign in_op      = t_op'(i_s_tuser);
    assign in_val     = i_s_tdata[VB-1:0];
    assign in_key     = i_s_tdata[VB+KEY_W-1:VB];

    assign o_m_tvalid = r_m_valid;
    assign o_m_tlast  = r_res.last;
    assign o_m_tdata  = OUT_W'({r_res.count, r_res.distance, r_res.rkey, r_res.rank,
                                r_res.status});

    // Derived settings and intake helpers.
    logic [EC_W-1:0]   lim;
    logic              dim_ok;
    logic              k_ok;
    logic              not_full;
    logic [EC_W-1:0]   ec_new;
    logic [EC_W-1:0]   n_fill;
    logic [PW-1:0]     tk;
    logic [SLOT_W-1:0] cnt_slot;
    logic [SLOT_W-1:0] last_slot;

    assign lim       = (int'(r_dim) > DIM_MAX) ? EC_W'(DIM_MAX) : EC_W'(r_dim);
    assign dim_ok    = (r_dim != '0) && (int'(r_dim) <= DIM_MAX);
    assign k_ok      = (r_top_k != '0) && (int'(r_top_k) <= K_MAX);
    assign not_full  = int'(r_count) < CAPACITY;
    assign ec_new    = (int'(r_ec) < DIM_MAX) ? r_ec + 1'b1 : r_ec;
    assign n_fill    = (ec_new < lim) ? ec_new : lim;
    assign tk        = PW'(r_top_k);
    assign cnt_slot  = r_count[SLOT_W-1:0];
    assign last_slot = SLOT_W'(r_count - 1'b1);

    // Shared score unit: one element difference or product per cycle.
    logic signed [VB:0]         diff;
    logic [VB:0]                mag;
    logic [63:0]                mag64;
    logic [SQ_LIM_W-1:0]        m24;
    logic [DIST_W-1:0]          sq;
    logic signed [2*VB-1:0]     prod;
    logic signed [TERM_W-1:0]   term_c;
    logic signed [TERM_W:0]     sum;
    logic signed [DIST_W-1:0]   acc_next;

    always_comb begin
        diff  = {r_qd[VB-1], r_qd} - {r_vd[VB-1], r_vd};
        mag   = diff[VB] ? (VB+1)'(-diff) : (VB+1)'(diff);
        mag64 = 64'(mag);
        m24   = mag64[SQ_LIM_W-1:0];
        sq    = m24 * m24;
        prod  = r_qd * r_vd;
        if (!r_metric) begin
            term_c = (|mag64[63:SQ_LIM_W]) ? TERM_W'(DIST_HI) : TERM_W'(sq);
        end else begin
            term_c = TERM_W'(prod);
        end
        sum = (TERM_W+1)'(r_acc) + (TERM_W+1)'(r_term);
        if (sum > (TERM_W+1)'(DIST_HI)) begin
            acc_next = DIST_HI;
        end else if (sum < (TERM_W+1)'(DIST_LO)) begin
            acc_next = DIST_LO;
        end else begin
            acc_next = DIST_W'(sum);
        end
    end

    // Ranked list read port and the insertion compare.
    logic [KW-1:0]            b_ra;
    logic signed [DIST_W-1:0] b_rd_score;
    logic [SLOT_W-1:0]        b_rd_slot;
    logic                     better;

    assign b_ra       = (r_state == S_INS) ? KW'(r_p - 1'b1) : KW'(r_j);
    assign b_rd_score = r_best_score[b_ra];
    assign b_rd_slot  = r_best_slot[b_ra];
    assign better     = r_metric ? (r_acc > b_rd_score) : (r_acc < b_rd_score);

    logic b_we;
    logic b_shift;

    assign b_shift = (r_p != '0) && better;
    assign b_we    = (r_state == S_INS) && (r_p < tk);

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_best_score[KW'(r_p)] <= b_shift ? b_rd_score : r_acc;
            r_best_slot[KW'(r_p)]  <= b_shift ? b_rd_slot  : r_slot;
        end
    end

    // Memory ports.
    logic              v_we;
    logic [AW-1:0]     v_wa;
    logic [AW-1:0]     v_ra;
    logic signed [VB-1:0] v_wd;
    logic              q_we;
    logic [E_W-1:0]    q_wa;
    logic signed [VB-1:0] q_wd;
    logic              k_we;
    logic [SLOT_W-1:0] k_wa;
    logic [SLOT_W-1:0] k_ra;
    logic [KEY_W-1:0]  k_wd;
    logic              idle_acc;
    logic              pos_ok;

    assign idle_acc = in_acc;
    assign pos_ok   = r_ec < lim;

    always_comb begin
        v_we = (idle_acc && in_op == OP_ADD && pos_ok && not_full)
            || (r_state == S_PAD_V && int'(r_e) < DIM_MAX)
            || (r_rm == RM_COPY && r_cp_v);
        if (r_rm == RM_COPY) begin
            v_wa = vaddr(r_rm_slot, EC_W'(r_ed));
            v_wd = r_vd;
            v_ra = vaddr(last_slot, r_e);
        end else begin
            v_wa = (r_state == S_IDLE) ? vaddr(cnt_slot, r_ec) : vaddr(cnt_slot, r_e);
            v_wd = (r_state == S_IDLE) ? in_val : '0;
            v_ra = vaddr(r_slot, r_e);
        end

        q_we = (idle_acc && in_op == OP_QRY && pos_ok)
            || (r_state == S_PAD_Q && int'(r_e) < DIM_MAX);
        q_wa = (r_state == S_IDLE) ? r_ec[E_W-1:0] : r_e[E_W-1:0];
        q_wd = (r_state == S_IDLE) ? in_val : '0;

        k_we = (idle_acc && in_op == OP_ADD && i_s_tlast && dim_ok && not_full
                && r_use_keys)
            || (r_rm == RM_COPY && r_e == EC_W'(1));
        k_wa = (r_rm == RM_COPY) ? r_rm_slot : cnt_slot;
        k_wd = (r_rm == RM_COPY) ? r_kd : in_key;
        if (r_rm == RM_COPY) begin
            k_ra = last_slot;
        end else if (r_state == S_RM_RD) begin
            k_ra = r_scan;
        end else begin
            k_ra = b_rd_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_vmem[v_wa] <= v_wd;
        end
        r_vd <= r_vmem[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_wa] <= q_wd;
        end
        r_qd <= r_qmem[r_e[E_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (k_we) begin
            r_kmem[k_wa] <= k_wd;
        end
        r_kd <= r_kmem[k_ra];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rm       <= RM_NONE;
            r_metric   <= METRIC_RST;
            r_dim      <= DIM_RST;
            r_top_k    <= TOPK_RST;
            r_use_keys <= USEK_RST;
            r_count    <= '0;
            r_ec       <= '0;
            r_rd_v     <= 1'b0;
            r_term_v   <= 1'b0;
            r_cp_v     <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_METRIC:   r_metric   <= i_cfg_data[0];
                    CFG_DIM:      r_dim      <= i_cfg_data[DIM_W-1:0];
                    CFG_TOPK:     r_top_k    <= i_cfg_data[TOPK_W-1:0];
                    CFG_USE_KEYS: r_use_keys <= i_cfg_data[0];
                endcase
            end

            r_rd_v   <= 1'b0;
            r_term_v <= r_rd_v;
            r_term   <= term_c;
            r_cp_v   <= 1'b0;

            if (r_rm == RM_CMP) begin
                if (r_kd == r_key) begin
                    r_rm_slot <= r_scan;
                    r_e       <= '0;
                    r_rm      <= RM_COPY;
                end else if (32'(r_scan) + 32'd1 < 32'(r_count)) begin
                    r_scan  <= r_scan + 1'b1;
                    r_rm    <= RM_NONE;
                    r_state <= S_RM_RD;
                end else begin
                    r_res     <= mk_single(ST_NOTFOUND, r_count);
                    r_m_valid <= 1'b1;
                    r_rm      <= RM_NONE;
                    r_state   <= S_RES;
                end
            end else if (r_rm == RM_COPY) begin
                // Read of the last slot runs one element ahead of the write.
                if (int'(r_e) < DIM_MAX) begin
                    r_cp_v <= 1'b1;
                    r_e    <= r_e + 1'b1;
                    r_ed   <= r_e[E_W-1:0];
                end else begin
                    r_count   <= r_count - 1'b1;
                    r_res     <= mk_single(ST_OK, r_count - 1'b1);
                    r_m_valid <= 1'b1;
                    r_rm      <= RM_NONE;
                    r_state   <= S_RES;
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_acc) begin
                            unique case (in_op)
                                OP_CLR: begin
                                    r_count   <= '0;
                                    r_ec      <= '0;
                                    r_res     <= mk_single(ST_OK, '0);
                                    r_m_valid <= 1'b1;
                                    r_state   <= S_RES;
                                end
                                OP_RM: begin
                                    r_ec  <= '0;
                                    r_key <= in_key;
                                    if (r_count == '0) begin
                                        r_res     <= mk_single(ST_NOTFOUND, r_count);
                                        r_m_valid <= 1'b1;
                                        r_state   <= S_RES;
                                    end else if (r_use_keys) begin
                                        r_scan  <= '0;
                                        r_state <= S_RM_RD;
                                    end else if (32'(in_key) < 32'(r_count)) begin
                                        r_rm_slot <= SLOT_W'(in_key);
                                        r_e       <= '0;
                                        r_rm      <= RM_COPY;
                                    end else begin
                                        r_res     <= mk_single(ST_NOTFOUND, r_count);
                                        r_m_valid <= 1'b1;
                                        r_state   <= S_RES;
                                    end
                                end
                                OP_ADD: begin
                                    if (!i_s_tlast) begin
                                        r_ec <= ec_new;
                                    end else begin
                                        r_ec <= '0;
                                        if (!dim_ok) begin
                                            r_res     <= mk_single(ST_BAD_PARM, r_count);
                                            r_m_valid <= 1'b1;
                                            r_state   <= S_RES;
                                        end else if (!not_full) begin
                                            r_res     <= mk_single(ST_INVALID, r_count);
                                            r_m_valid <= 1'b1;
                                            r_state   <= S_RES;
                                        end else begin
                                            r_e     <= n_fill;
                                            r_state <= S_PAD_V;
                                        end
                                    end
                                end
                                OP_QRY: begin
                                    if (!i_s_tlast) begin
                                        r_ec <= ec_new;
                                    end else begin
                                        r_ec <= '0;
                                        if (!dim_ok || !k_ok) begin
                                            r_res     <= mk_single(ST_BAD_PARM, r_count);
                                            r_m_valid <= 1'b1;
                                            r_state   <= S_RES;
                                        end else if (r_count == '0) begin
                                            r_res     <= mk_single(ST_INVALID, r_count);
                                            r_m_valid <= 1'b1;
                                            r_state   <= S_RES;
                                        end else begin
                                            r_e     <= n_fill;
                                            r_state <= S_PAD_Q;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                    S_RES: begin
                        if (i_m_tready) begin
                            r_m_valid <= 1'b0;
                            r_state   <= S_IDLE;
                        end
                    end
                    S_PAD_V: begin
                        if (int'(r_e) < DIM_MAX) begin
                            r_e <= r_e + 1'b1;
                        end else begin
                            r_count   <= r_count + 1'b1;
                            r_res     <= mk_single(ST_OK, r_count + 1'b1);
                            r_m_valid <= 1'b1;
                            r_state   <= S_RES;
                        end
                    end
                    S_PAD_Q: begin
                        if (int'(r_e) < DIM_MAX) begin
                            r_e <= r_e + 1'b1;
                        end else begin
                            r_slot  <= '0;
                            r_len   <= '0;
                            r_e     <= '0;
                            r_acc   <= '0;
                            r_state <= S_RUN;
                        end
                    end
                    S_RUN: begin
                        if (r_e < lim) begin
                            r_rd_v <= 1'b1;
                            r_e    <= r_e + 1'b1;
                        end
                        if (r_term_v) begin
                            r_acc <= acc_next;
                        end
                        if (r_e >= lim && !r_rd_v && !r_term_v) begin
                            r_p     <= (r_len < tk) ? r_len : tk;
                            r_state <= S_INS;
                        end
                    end
                    S_INS: begin
                        // Walk up the list one entry a cycle; ties keep the earlier slot.
                        if (b_shift) begin
                            r_p <= r_p - 1'b1;
                        end else begin
                            if (r_p < tk && r_len < tk) begin
                                r_len <= r_len + 1'b1;
                            end
                            if (32'(r_slot) + 32'd1 < 32'(r_count)) begin
                                r_slot  <= r_slot + 1'b1;
                                r_e     <= '0;
                                r_acc   <= '0;
                                r_state <= S_RUN;
                            end else begin
                                r_j     <= '0;
                                r_state <= S_OUT_KEY;
                            end
                        end
                    end
                    S_OUT_KEY: begin
                        r_state <= S_OUT_LD;
                    end
                    S_OUT_LD: begin
                        r_res.status <= ST_OK;
                        r_res.rank   <= RANK_W'(r_j);
                        r_res.count  <= r_count;
                        r_res.last   <= (32'(r_j) + 32'd1 == 32'(r_top_k));
                        if (r_j < r_len) begin
                            r_res.rkey     <= r_use_keys ? RKEY_W'(r_kd) : RKEY_W'(b_rd_slot);
                            r_res.distance <= b_rd_score;
                        end else begin
                            r_res.rkey     <= '1;
                            r_res.distance <= DIST_HI;
                        end
                        r_m_valid <= 1'b1;
                        r_state   <= S_OUT_WAIT;
                    end
                    S_OUT_WAIT: begin
                        if (i_m_tready) begin
                            r_m_valid <= 1'b0;
                            if (r_res.last) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_j     <= r_j + 1'b1;
                                r_state <= S_OUT_KEY;
                            end
                        end
                    end
                    S_RM_RD: begin
                        r_rm    <= RM_CMP;
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
